[sv/skt_pkg.sv]
`default_nettype none

package skt_pkg;

  // Field widths of one word on each side.
  localparam int ACT_W     = 2;
  localparam int KEY_W     = 34;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int POS_W     = 4;
  localparam int TOT_W     = 5;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 48;

  localparam int CAPACITY_DEF = 16;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_COMPARE,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_in;
    logic              rd_mid;
    logic              step;
    logic              rd_lo;
    logic              rd_shift;
    logic              wr_shift;
    logic              ptr_from_lo;
    logic              place;
    logic              dec_count;
    logic              capture_found;
    logic              set_code;
    logic [STAT_W-1:0] code;
    logic              finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ins;
    logic del;
    logic full;
    logic lo_lt_hi;
    logic lo_lt_count;
    logic rd_lt;
    logic rd_eq;
    logic ins_shift;
    logic del_shift;
    logic shift_more;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[sv/skt_ctrl.sv]
`default_nettype none

module skt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire skt_pkg::stat_t st,
  output skt_pkg::cmd_t      cmd
);

  skt_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      skt_pkg::S_IDLE: begin
        if (s_tvalid) state_next = skt_pkg::S_START;
      end
      skt_pkg::S_START: begin
        if (st.ins && st.full) state_next = skt_pkg::S_DONE;
        else state_next = skt_pkg::S_PROBE;
      end
      skt_pkg::S_PROBE: begin
        if (st.lo_lt_hi) state_next = skt_pkg::S_COMPARE;
        else if (st.ins) state_next = st.ins_shift ? skt_pkg::S_SHIFT_RD : skt_pkg::S_PLACE;
        else if (st.lo_lt_count) state_next = skt_pkg::S_CHECK;
        else state_next = skt_pkg::S_DONE;
      end
      skt_pkg::S_COMPARE: begin
        state_next = skt_pkg::S_PROBE;
      end
      skt_pkg::S_CHECK: begin
        if (st.rd_eq && st.del && st.del_shift) state_next = skt_pkg::S_SHIFT_RD;
        else state_next = skt_pkg::S_DONE;
      end
      skt_pkg::S_SHIFT_RD: begin
        state_next = skt_pkg::S_SHIFT_WR;
      end
      skt_pkg::S_SHIFT_WR: begin
        if (st.shift_more) state_next = skt_pkg::S_SHIFT_RD;
        else if (st.ins) state_next = skt_pkg::S_PLACE;
        else state_next = skt_pkg::S_DONE;
      end
      skt_pkg::S_PLACE: begin
        state_next = skt_pkg::S_DONE;
      end
      skt_pkg::S_DONE: begin
        if (st.out_free) state_next = skt_pkg::S_IDLE;
      end
      default: begin
        state_next = skt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      skt_pkg::S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      skt_pkg::S_START: begin
        if (st.ins && st.full) begin
          cmd.set_code = 1'b1;
          cmd.code     = skt_pkg::STAT_FULL;
        end
      end
      skt_pkg::S_PROBE: begin
        if (st.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
        end else if (!st.ins) begin
          if (st.lo_lt_count) begin
            cmd.rd_lo = 1'b1;
          end else begin
            cmd.set_code = 1'b1;
            cmd.code     = skt_pkg::STAT_MISS;
          end
        end
      end
      skt_pkg::S_COMPARE: begin
        cmd.step = 1'b1;
      end
      skt_pkg::S_CHECK: begin
        cmd.set_code = 1'b1;
        if (st.rd_eq) begin
          cmd.code          = skt_pkg::STAT_OK;
          cmd.capture_found = 1'b1;
          cmd.ptr_from_lo   = 1'b1;
          cmd.dec_count     = st.del && !st.del_shift;
        end else begin
          cmd.code = skt_pkg::STAT_MISS;
        end
      end
      skt_pkg::S_SHIFT_RD: begin
        cmd.rd_shift = 1'b1;
      end
      skt_pkg::S_SHIFT_WR: begin
        cmd.wr_shift  = 1'b1;
        cmd.dec_count = !st.shift_more && !st.ins;
      end
      skt_pkg::S_PLACE: begin
        cmd.place    = 1'b1;
        cmd.set_code = 1'b1;
        cmd.code     = skt_pkg::STAT_OK;
      end
      skt_pkg::S_DONE: begin
        cmd.finish = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/skt_datapath.sv]
`default_nettype none

module skt_datapath #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [skt_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic [skt_pkg::ACT_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [skt_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic [skt_pkg::STAT_W-1:0]         m_tuser,
  input  wire skt_pkg::cmd_t                 cmd,
  output skt_pkg::stat_t                     st
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int KW = skt_pkg::KEY_W;
  localparam int VW = skt_pkg::VAL_W;

  logic [KW-1:0] key_mem [CAPACITY];
  logic [VW-1:0] val_mem [CAPACITY];

  logic [skt_pkg::ACT_W-1:0]  act_reg;
  logic [KW-1:0]              key_reg;
  logic [VW-1:0]              val_reg;
  logic [CW-1:0]              lo, hi, mid_q, ptr, count;
  logic [KW-1:0]              rd_key;
  logic [VW-1:0]              rd_val;
  logic [VW-1:0]              found;
  logic [skt_pkg::STAT_W-1:0] code_reg;

  logic [skt_pkg::STAT_W-1:0] out_status;
  logic [skt_pkg::POS_W-1:0]  out_pos;
  logic [VW-1:0]              out_fval;
  logic [skt_pkg::TOT_W-1:0]  out_total;

  logic [CW-1:0]               mid;
  logic [CW:0]                 ptr_m1, ptr_p1, ptr_p2, lo_p1;
  logic                        rd_en, wr_en;
  logic [IW-1:0]               raddr, waddr;
  logic [KW-1:0]               wkey;
  logic [VW-1:0]               wval;
  logic [CW+skt_pkg::POS_W-1:0] lo_ext;
  logic [CW+skt_pkg::TOT_W-1:0] count_ext;
  logic                        ins, del;

  assign ins    = (act_reg == skt_pkg::ACT_INSERT);
  assign del    = (act_reg == skt_pkg::ACT_DELETE);
  assign mid    = lo + ((hi - lo) >> 1);
  assign ptr_m1 = {1'b0, ptr} - 1'b1;
  assign ptr_p1 = {1'b0, ptr} + 1'b1;
  assign ptr_p2 = {1'b0, ptr} + 2'd2;
  assign lo_p1  = {1'b0, lo} + 1'b1;

  assign lo_ext    = {{skt_pkg::POS_W{1'b0}}, lo};
  assign count_ext = {{skt_pkg::TOT_W{1'b0}}, count};

  always_comb begin
    st             = '0;
    st.ins         = ins;
    st.del         = del;
    st.full        = (count == CW'(CAPACITY));
    st.lo_lt_hi    = (lo < hi);
    st.lo_lt_count = (lo < count);
    st.rd_lt       = (rd_key < key_reg);
    st.rd_eq       = (rd_key == key_reg);
    st.ins_shift   = (count > lo);
    st.del_shift   = (lo_p1 < {1'b0, count});
    st.shift_more  = ins ? ({1'b0, ptr} > lo_p1) : (ptr_p2 < {1'b0, count});
    st.out_free    = !m_tvalid || m_tready;
  end

  // Memory port selection: one read and one write per cycle.
  always_comb begin
    rd_en = cmd.rd_mid || cmd.rd_lo || cmd.rd_shift;
    if (cmd.rd_mid) begin
      raddr = mid[IW-1:0];
    end else if (cmd.rd_lo) begin
      raddr = lo[IW-1:0];
    end else begin
      raddr = ins ? ptr_m1[IW-1:0] : ptr_p1[IW-1:0];
    end
    wr_en = cmd.wr_shift || cmd.place;
    if (cmd.place) begin
      waddr = lo[IW-1:0];
      wkey  = key_reg;
      wval  = val_reg;
    end else begin
      waddr = ptr[IW-1:0];
      wkey  = rd_key;
      wval  = rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[raddr];
      rd_val <= val_mem[raddr];
    end
    if (wr_en) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_reg <= s_tuser;
      key_reg <= s_tdata[KW-1:0];
      val_reg <= s_tdata[KW+VW-1:KW];
      lo      <= '0;
      hi      <= count;
      ptr     <= count;
      found   <= '0;
    end
    if (cmd.rd_mid) begin
      mid_q <= mid;
    end
    if (cmd.step) begin
      if (rd_key < key_reg) begin
        lo <= mid_q + 1'b1;
      end else begin
        hi <= mid_q;
      end
    end
    if (cmd.ptr_from_lo) begin
      ptr <= lo;
    end else if (cmd.wr_shift) begin
      ptr <= ins ? ptr_m1[CW-1:0] : ptr_p1[CW-1:0];
    end
    if (cmd.capture_found) begin
      found <= rd_val;
    end
    if (cmd.set_code) begin
      code_reg <= cmd.code;
    end
    if (cmd.finish) begin
      out_status <= code_reg;
      out_pos    <= (code_reg == skt_pkg::STAT_OK) ? lo_ext[skt_pkg::POS_W-1:0] : '0;
      out_fval   <= found;
      out_total  <= count_ext[skt_pkg::TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.place) begin
        count <= count + 1'b1;
      end else if (cmd.dec_count) begin
        count <= count - 1'b1;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {{(skt_pkg::M_TDATA_W - skt_pkg::TOT_W - VW - skt_pkg::POS_W){1'b0}},
                    out_total, out_fval, out_pos};

endmodule

`default_nettype wire

[sv/sorted_key_table.sv]
// Channel | Direction | Signals                       | Content
// --------+-----------+-------------------------------+----------------------------------
// s       | in        | s_tvalid s_tready s_tdata     | request word: action, key, handle
//         |           | s_tuser                       |
// m       | out       | m_tvalid m_tready m_tdata     | response word: status, position,
//         |           | m_tuser                       | found handle, entry total
//
// One request word is handled at a time. A lookup or delete runs a binary search
// with at most ceil(log2(N+1)) probes for N stored entries, each probe being one
// memory read followed by a compare, then reads the entry at the found position;
// a miss past the last entry skips that read, and an insert into a full table
// skips the search. Insert and delete move entries one at a time, and because the
// read data of the table memory is registered, each move is a read followed by a
// write. Reset is synchronous and clears the controller state, the entry count
// and the output valid; table contents are undefined until written.
// A response waiting on a stalled m_tready holds its output register, and the
// next request is taken while it waits.
`default_nettype none

module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request word.
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // Bits from low up: key [33:0], record_value [65:34], zero pad [71:66].
  input  wire logic [skt_pkg::S_TDATA_W-1:0] s_tdata,
  // Bits from low up: action [1:0].
  input  wire logic [skt_pkg::ACT_W-1:0]     s_tuser,
  // Response word.
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // Bits from low up: position [3:0], found_value [35:4], entry_total [40:36],
  // zero pad [47:41].
  output logic [skt_pkg::M_TDATA_W-1:0]      m_tdata,
  // Bits from low up: status [1:0].
  output logic [skt_pkg::STAT_W-1:0]         m_tuser
);

  skt_pkg::cmd_t  cmd;
  skt_pkg::stat_t st;

  // The controller sequences the search, the entry moves and the response.
  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the sorted key and handle memories, the search bounds,
  // the move pointer, the entry count and the response register.
  skt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .st       (st)
  );

endmodule

`default_nettype wire

[sv/skt_checker.sv]
`default_nettype none

module skt_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [skt_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [skt_pkg::STAT_W-1:0]    m_tuser
);

  // A stalled response holds its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("response word changed while stalled");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  // A miss or a full table reports position and handle as zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != skt_pkg::STAT_OK |->
      m_tdata[skt_pkg::POS_W+skt_pkg::VAL_W-1:0] == '0)
    else $error("failed action reports a position or handle");

  // Reset leaves no response pending and the request side open.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);

`default_nettype wire
